/* rtl/core/sliding_window_retransmit_sender_unit_assert.svh */
// assertion macros shared by the sender window rtl
// expects clk and rst_n in the scope of each use
`ifndef SLIDING_WINDOW_RETRANSMIT_SENDER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_RETRANSMIT_SENDER_UNIT_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define SWRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swrs assertion failed");

// consequence must hold in the cycle after the antecedent
`define SWRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swrs assertion failed");

`endif

/* rtl/core/swrs_pkg.sv */
// shared constants, codes, types and helpers of the sender window
// no dependencies
`default_nettype none

package swrs_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int OCC_W       = $clog2(SLOTS + 1);
    localparam int PAYLOAD_MAX = 1024;
    localparam int LEN_W       = 11;
    localparam int TIME_WIDTH  = 32;
    localparam int SEQ_W       = 32;
    localparam int ACK_W       = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int KIND_W      = 2;
    localparam int ACTION_W    = 2;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int UNIT_W      = (TIME_WIDTH > SEQ_W) ? TIME_WIDTH : SEQ_W;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);
    localparam logic [OCC_W-1:0]     OCC_HALF      = OCC_W'(SLOTS / 2);
    localparam logic [OCC_W-1:0]     OCC_FULL      = OCC_W'(SLOTS);
    localparam logic [SLOT_W-1:0]    LAST_SLOT     = SLOT_W'(SLOTS - 1);
    localparam logic [LEN_W-1:0]     LEN_MAX       = LEN_W'(PAYLOAD_MAX);

    // input kinds
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OFFER = 2'd2;

    // result actions
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NEW    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESEND = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_REFUSE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 1'd1;

    // compare unit modes
    localparam logic CMP_ACK = 1'b0;
    localparam logic CMP_AGE = 1'b1;

    typedef struct packed {
        logic                  we_entry;
        logic                  we_stamp;
        logic [SLOT_W-1:0]     addr;
        logic [SEQ_W-1:0]      seq;
        logic [LEN_W-1:0]      len;
        logic [TIME_WIDTH-1:0] stamp;
    } store_wr_t;

    typedef struct packed {
        logic [SEQ_W-1:0]      seq;
        logic [LEN_W-1:0]      len;
        logic [TIME_WIDTH-1:0] stamp;
    } store_rd_t;

    typedef struct packed {
        logic              mode;
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
        logic [UNIT_W-1:0] limit;
    } cmp_req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } free_t;

    // lowest slot whose busy bit is clear
    function automatic free_t find_free(input logic [SLOTS-1:0] busy);
        free_t r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy[i])
            begin
                r.found = 1'b1;
                r.idx   = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/swrs_item_if.sv */
// input channel of the sender window: kind, ack number and offer length
// depends on swrs_pkg
`default_nettype none

interface swrs_item_if;
    logic                             valid;
    logic                             ready;
    logic [swrs_pkg::KIND_W-1:0]      kind;
    logic [swrs_pkg::ACK_W-1:0]       ack_number;
    logic [swrs_pkg::LEN_W-1:0]       offer_len;

    modport source (output valid, output kind, output ack_number, output offer_len,
                    input ready);
    modport sink   (input valid, input kind, input ack_number, input offer_len,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/swrs_result_if.sv */
// result channel of the sender window: one beat per send, resend or status
// depends on swrs_pkg
`default_nettype none

interface swrs_result_if;
    logic                             valid;
    logic                             ready;
    logic [swrs_pkg::ACTION_W-1:0]    action;
    logic [swrs_pkg::SLOT_W-1:0]      slot;
    logic [swrs_pkg::SEQ_W-1:0]       seq_out;
    logic [swrs_pkg::LEN_W-1:0]       sent_len;
    logic [swrs_pkg::OCC_W-1:0]       occupancy;
    logic                             finished;
    logic                             last;

    modport source (output valid, output action, output slot, output seq_out,
                    output sent_len, output occupancy, output finished, output last,
                    input ready);
    modport sink   (input valid, input action, input slot, input seq_out,
                    input sent_len, input occupancy, input finished, input last,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/swrs_slot_store.sv */
// slot store: sequence, length and stamp per window slot
// one write port (entry or stamp only), one registered read port; depends on swrs_pkg
`default_nettype none

module swrs_slot_store (
    input  wire logic                          clk,
    input  wire swrs_pkg::store_wr_t           wr,
    input  wire logic [swrs_pkg::SLOT_W-1:0]   rd_addr,
    output swrs_pkg::store_rd_t                rd
);

    logic [swrs_pkg::SEQ_W-1:0]      seq_mem   [swrs_pkg::SLOTS];
    logic [swrs_pkg::LEN_W-1:0]      len_mem   [swrs_pkg::SLOTS];
    logic [swrs_pkg::TIME_WIDTH-1:0] stamp_mem [swrs_pkg::SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.we_entry)
        begin
            seq_mem[wr.addr] <= wr.seq;
            len_mem[wr.addr] <= wr.len;
        end
        if (wr.we_entry || wr.we_stamp)
        begin
            stamp_mem[wr.addr] <= wr.stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        rd.seq   <= seq_mem[rd_addr];
        rd.len   <= len_mem[rd_addr];
        rd.stamp <= stamp_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/swrs_cmp_unit.sv */
// shared subtract and compare unit used by the ack and timeout scans
// depends on swrs_pkg
`default_nettype none

module swrs_cmp_unit (
    input  wire swrs_pkg::cmp_req_t req,
    output logic                    hit
);

    logic [swrs_pkg::UNIT_W:0]       diff;
    logic [swrs_pkg::UNIT_W-1:0]     val;
    logic                            borrow;

    always_comb
    begin
        diff   = {1'b0, req.a} - {1'b0, req.b};
        borrow = diff[swrs_pkg::UNIT_W];
        // ack mode keeps the full difference, age mode wraps at the time width
        if (req.mode == swrs_pkg::CMP_ACK)
        begin
            val = diff[swrs_pkg::UNIT_W-1:0];
        end
        else
        begin
            val = swrs_pkg::UNIT_W'(diff[swrs_pkg::TIME_WIDTH-1:0]);
        end
        hit = (val >= req.limit) && !((req.mode == swrs_pkg::CMP_ACK) && borrow);
    end

endmodule

`default_nettype wire

/* rtl/core/sliding_window_retransmit_sender_unit.sv */
// Sender window with eight slots. An item is taken only while the sequencer is
// idle. An ack or a tick walks the slots one at a time through the slot store
// and the shared compare unit: a read and an evaluate state per occupied slot,
// a read state per free slot, plus an accept state before the walk and a final
// beat after it. An offer or an unused kind passes only the accept state and
// its beat state. The split follows from the single registered read port of the
// slot store. A result beat waits in an output register; the next item is
// accepted while it waits, and the walk stalls only when a new beat must leave.
//
// top level of the sender window; depends on swrs_pkg, swrs_item_if,
// swrs_result_if, swrs_slot_store, swrs_cmp_unit and the assert header
`default_nettype none
`include "sliding_window_retransmit_sender_unit_assert.svh"

module sliding_window_retransmit_sender_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [swrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [swrs_pkg::CFG_W-1:0]       cfg_data,
    swrs_item_if.sink                             item,
    swrs_result_if.source                         result
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_RD    = 3'd1;
    localparam logic [ST_W-1:0] ST_EV    = 3'd2;
    localparam logic [ST_W-1:0] ST_OFFER = 3'd3;
    localparam logic [ST_W-1:0] ST_FIN   = 3'd4;

    logic [ST_W-1:0]                   state_reg, state_next;
    logic [swrs_pkg::SLOT_W-1:0]       idx_reg, idx_next;
    logic [swrs_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic [swrs_pkg::ACK_W-1:0]        ack_reg, ack_next;
    logic [swrs_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [swrs_pkg::SLOTS-1:0]        busy_reg, busy_next;
    logic [swrs_pkg::OCC_W-1:0]        occ_reg, occ_next;
    logic [swrs_pkg::SEQ_W-1:0]        next_seq_reg, next_seq_next;
    logic [swrs_pkg::TIME_WIDTH-1:0]   time_reg, time_next;
    logic                              file_done_reg, file_done_next;
    logic                              refilling_reg, refilling_next;
    logic [swrs_pkg::TIMEOUT_W-1:0]    timeout_reg, timeout_next;

    // pending resend, held back until we know whether it is the last beat
    logic                              hold_valid_reg, hold_valid_next;
    logic [swrs_pkg::SLOT_W-1:0]       hold_slot_reg, hold_slot_next;
    logic [swrs_pkg::SEQ_W-1:0]        hold_seq_reg, hold_seq_next;
    logic [swrs_pkg::LEN_W-1:0]        hold_len_reg, hold_len_next;

    logic                              res_valid_reg, res_valid_next;
    logic [swrs_pkg::ACTION_W-1:0]     res_action_reg;
    logic [swrs_pkg::SLOT_W-1:0]       res_slot_reg;
    logic [swrs_pkg::SEQ_W-1:0]        res_seq_reg;
    logic [swrs_pkg::LEN_W-1:0]        res_len_reg;
    logic [swrs_pkg::OCC_W-1:0]        res_occ_reg;
    logic                              res_finished_reg;
    logic                              res_last_reg;

    logic                              emit;
    logic [swrs_pkg::ACTION_W-1:0]     emit_action;
    logic [swrs_pkg::SLOT_W-1:0]       emit_slot;
    logic [swrs_pkg::SEQ_W-1:0]        emit_seq;
    logic [swrs_pkg::LEN_W-1:0]        emit_len;
    logic [swrs_pkg::OCC_W-1:0]        emit_occ;
    logic                              emit_finished;
    logic                              emit_last;

    logic                              can_emit;
    logic                              hit;
    logic                              offer_refuse;
    logic                              offer_done;
    logic [swrs_pkg::LEN_W-1:0]        offer_sat;
    logic [swrs_pkg::OCC_W-1:0]        offer_occ;
    swrs_pkg::free_t                   free_slot;
    swrs_pkg::store_wr_t               wr;
    swrs_pkg::store_rd_t               rd;
    swrs_pkg::cmp_req_t                cmp_req;

    swrs_slot_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (idx_reg),
        .rd      (rd)
    );

    swrs_cmp_unit u_cmp (
        .req (cmp_req),
        .hit (hit)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign can_emit   = !res_valid_reg || result.ready;

    assign result.valid     = res_valid_reg;
    assign result.action    = res_action_reg;
    assign result.slot      = res_slot_reg;
    assign result.seq_out   = res_seq_reg;
    assign result.sent_len  = res_len_reg;
    assign result.occupancy = res_occ_reg;
    assign result.finished  = res_finished_reg;
    assign result.last      = res_last_reg;

    // operands for the shared unit: ack against slot seq, or age against timeout
    always_comb
    begin
        if (kind_reg == swrs_pkg::KIND_ACK)
        begin
            cmp_req.mode  = swrs_pkg::CMP_ACK;
            cmp_req.a     = swrs_pkg::UNIT_W'(ack_reg);
            cmp_req.b     = swrs_pkg::UNIT_W'(rd.seq);
            cmp_req.limit = swrs_pkg::UNIT_W'(2);
        end
        else
        begin
            cmp_req.mode  = swrs_pkg::CMP_AGE;
            cmp_req.a     = swrs_pkg::UNIT_W'(time_reg);
            cmp_req.b     = swrs_pkg::UNIT_W'(rd.stamp);
            cmp_req.limit = swrs_pkg::UNIT_W'(timeout_reg);
        end
    end

    always_comb
    begin
        free_slot    = swrs_pkg::find_free(busy_reg);
        offer_sat    = (len_reg > swrs_pkg::LEN_MAX) ? swrs_pkg::LEN_MAX : len_reg;
        offer_refuse = !refilling_reg || file_done_reg || !free_slot.found;
        offer_done   = file_done_reg || (offer_sat < swrs_pkg::LEN_MAX);
        offer_occ    = occ_reg + swrs_pkg::OCC_W'(1);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        ack_next        = ack_reg;
        len_next        = len_reg;
        busy_next       = busy_reg;
        occ_next        = occ_reg;
        next_seq_next   = next_seq_reg;
        time_next       = time_reg;
        file_done_next  = file_done_reg;
        refilling_next  = refilling_reg;
        timeout_next    = timeout_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_seq_next   = hold_seq_reg;
        hold_len_next   = hold_len_reg;

        wr          = '0;
        wr.addr     = idx_reg;
        wr.stamp    = time_reg;

        emit          = 1'b0;
        emit_action   = swrs_pkg::ACT_NONE;
        emit_slot     = '0;
        emit_seq      = '0;
        emit_len      = '0;
        emit_occ      = occ_reg;
        emit_finished = file_done_reg && (occ_reg == '0);
        emit_last     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    kind_next = item.kind;
                    ack_next  = item.ack_number;
                    len_next  = item.offer_len;
                    idx_next  = '0;
                    unique case (item.kind)
                        swrs_pkg::KIND_ACK:
                        begin
                            state_next = ST_RD;
                        end
                        swrs_pkg::KIND_TICK:
                        begin
                            time_next  = time_reg + swrs_pkg::TIME_WIDTH'(1);
                            state_next = ST_RD;
                        end
                        swrs_pkg::KIND_OFFER:
                        begin
                            state_next = ST_OFFER;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                // read of idx_reg is issued at this edge when the slot is busy
                if (busy_reg[idx_reg])
                begin
                    state_next = ST_EV;
                end
                else if (idx_reg == swrs_pkg::LAST_SLOT)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + swrs_pkg::SLOT_W'(1);
                end
            end

            ST_EV:
            begin
                if (!(kind_reg == swrs_pkg::KIND_TICK && hit && hold_valid_reg && !can_emit))
                begin
                    if (kind_reg == swrs_pkg::KIND_ACK)
                    begin
                        if (hit)
                        begin
                            busy_next[idx_reg] = 1'b0;
                            occ_next           = occ_reg - swrs_pkg::OCC_W'(1);
                        end
                    end
                    else if (hit)
                    begin
                        if (hold_valid_reg)
                        begin
                            emit        = 1'b1;
                            emit_action = swrs_pkg::ACT_RESEND;
                            emit_slot   = hold_slot_reg;
                            emit_seq    = hold_seq_reg;
                            emit_len    = hold_len_reg;
                            emit_last   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = idx_reg;
                        hold_seq_next   = rd.seq;
                        hold_len_next   = rd.len;
                        wr.we_stamp     = 1'b1;
                    end
                    if (idx_reg == swrs_pkg::LAST_SLOT)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + swrs_pkg::SLOT_W'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_OFFER:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (offer_refuse)
                    begin
                        emit_action = swrs_pkg::ACT_REFUSE;
                    end
                    else
                    begin
                        busy_next[free_slot.idx] = 1'b1;
                        occ_next                 = offer_occ;
                        wr.we_entry              = 1'b1;
                        wr.addr                  = free_slot.idx;
                        wr.seq                   = next_seq_reg;
                        wr.len                   = offer_sat;
                        next_seq_next  = next_seq_reg + swrs_pkg::SEQ_W'(offer_sat);
                        file_done_next = offer_done;
                        if (offer_done || (offer_occ >= swrs_pkg::OCC_FULL))
                        begin
                            refilling_next = 1'b0;
                        end
                        emit_action   = swrs_pkg::ACT_NEW;
                        emit_slot     = free_slot.idx;
                        emit_seq      = next_seq_reg;
                        emit_len      = offer_sat;
                        emit_occ      = offer_occ;
                        emit_finished = offer_done && (offer_occ == '0);
                    end
                end
            end

            ST_FIN:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (kind_reg == swrs_pkg::KIND_ACK)
                    begin
                        if ((occ_reg < swrs_pkg::OCC_HALF) && !file_done_reg)
                        begin
                            refilling_next = 1'b1;
                        end
                    end
                    else if (kind_reg == swrs_pkg::KIND_TICK && hold_valid_reg)
                    begin
                        emit_action     = swrs_pkg::ACT_RESEND;
                        emit_slot       = hold_slot_reg;
                        emit_seq        = hold_seq_reg;
                        emit_len        = hold_len_reg;
                        hold_valid_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes are to arrive only while idle; the block does not enforce it
        if (cfg_we)
        begin
            unique case (cfg_index)
                swrs_pkg::CFG_TIMEOUT:
                begin
                    timeout_next = cfg_data[swrs_pkg::TIMEOUT_W-1:0];
                end
                swrs_pkg::CFG_START_SEQ:
                begin
                    next_seq_next = cfg_data[swrs_pkg::SEQ_W-1:0];
                end
                default:
                begin
                    timeout_next = timeout_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            kind_reg       <= swrs_pkg::KIND_ACK;
            busy_reg       <= '0;
            occ_reg        <= '0;
            next_seq_reg   <= '0;
            time_reg       <= '0;
            file_done_reg  <= 1'b0;
            refilling_reg  <= 1'b1;
            timeout_reg    <= swrs_pkg::TIMEOUT_RESET;
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            kind_reg       <= kind_next;
            busy_reg       <= busy_next;
            occ_reg        <= occ_next;
            next_seq_reg   <= next_seq_next;
            time_reg       <= time_next;
            file_done_reg  <= file_done_next;
            refilling_reg  <= refilling_next;
            timeout_reg    <= timeout_next;
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg      <= ack_next;
        len_reg      <= len_next;
        hold_slot_reg <= hold_slot_next;
        hold_seq_reg  <= hold_seq_next;
        hold_len_reg  <= hold_len_next;
        if (emit)
        begin
            res_action_reg   <= emit_action;
            res_slot_reg     <= emit_slot;
            res_seq_reg      <= emit_seq;
            res_len_reg      <= emit_len;
            res_occ_reg      <= emit_occ;
            res_finished_reg <= emit_finished;
            res_last_reg     <= emit_last;
        end
    end

    // occupancy counter tracks the busy bits
    `SWRS_ASSERT_NOW(a_occ_matches_busy, 1'b1, occ_reg == swrs_pkg::OCC_W'($countones(busy_reg)))
    // a slot is only evaluated while it is occupied
    `SWRS_ASSERT_NOW(a_eval_busy, state_reg == ST_EV, busy_reg[idx_reg])
    // a held resend exists only inside a tick walk and is gone once idle
    `SWRS_ASSERT_NOW(a_hold_tick, hold_valid_reg, kind_reg == swrs_pkg::KIND_TICK && state_reg != ST_IDLE)
    // between items refill is off once the file ended or the window is full
    `SWRS_ASSERT_NOW(a_refill_idle, state_reg == ST_IDLE && refilling_reg, !file_done_reg && occ_reg != swrs_pkg::OCC_FULL)
    // the final beat of an item always leads back to idle
    `SWRS_ASSERT_NEXT(a_last_idle, emit && emit_last, state_reg == ST_IDLE)

endmodule

`default_nettype wire
